[sv/vfdcg_pkg.sv]
// ----------------------------------------------------------------------------
// vfdcg_pkg
// Shared types, constants and helpers of the drive command frame generator.
// ----------------------------------------------------------------------------
package vfdcg_pkg;

  // speed field width and derived product widths
  localparam int SPEED_W = 24;
  localparam int M100_W  = SPEED_W + 7;
  localparam int PROD_W  = M100_W + 16;

  // input command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_INIT     = 2'd1;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_CMD_SCALE  = 2'd1;
  localparam logic [1:0] CFG_FREQ_LIMIT = 2'd2;

  // reset values of the registers
  localparam logic [15:0] SCALE_RESET = 16'd256;
  localparam logic [15:0] LIMIT_RESET = 16'd40000;
  localparam logic [15:0] SCALE_UNITY = 16'd256;

  // link characters
  localparam logic [7:0] CH_ENQ  = 8'h05;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_F    = 8'h46;

  // frame data lengths
  localparam logic [2:0] DLEN_NONE = 3'd0;
  localparam logic [2:0] DLEN_TWO  = 3'd2;
  localparam logic [2:0] DLEN_FOUR = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               run_request;
    logic               forward_dir;
    logic               estop_ok;
    logic signed [SPEED_W-1:0] speed_command;
  } vfdcg_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;
  } vfdcg_out_t;

  // one frame to send: code, data bytes (element 0 goes first), length
  typedef struct packed {
    logic [7:0]      c0;
    logic [7:0]      c1;
    logic [3:0][7:0] data;
    logic [2:0]      dlen;
    logic            last;
  } vfdcg_frame_t;

  typedef enum logic [1:0] {TOP_IDLE, TOP_CALC, TOP_EMIT, TOP_WAIT} vfdcg_top_state_e;
  typedef enum logic [1:0] {MUL_IDLE, MUL_RUN, MUL_SAT} vfdcg_mul_state_e;
  typedef enum logic {FR_IDLE, FR_SEND} vfdcg_fr_state_e;

  // nibble to uppercase ascii hex
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = CH_0 + {4'd0, nib};
    else             c = CH_A + {4'd0, nib} - 8'd10;
    return c;
  endfunction

  // tens digit of a station number 0..31
  function automatic logic [1:0] st_tens(input logic [4:0] st);
    logic [1:0] t;
    if (st >= 5'd30)      t = 2'd3;
    else if (st >= 5'd20) t = 2'd2;
    else if (st >= 5'd10) t = 2'd1;
    else                  t = 2'd0;
    return t;
  endfunction

  // ones digit of a station number 0..31
  function automatic logic [3:0] st_ones(input logic [4:0] st);
    logic [4:0] r;
    case (st_tens(st))
      2'd3:    r = st - 5'd30;
      2'd2:    r = st - 5'd20;
      2'd1:    r = st - 5'd10;
      default: r = st;
    endcase
    return r[3:0];
  endfunction

endpackage

[sv/vfd_command_frame_generator_top.sv]
// ----------------------------------------------------------------------------
// vfd_command_frame_generator_top
// Drive command frame generator: change detection, frame queueing, config.
// ----------------------------------------------------------------------------
// One input beat is taken while the block is idle; it then queues up to three
// frames (estop return, run/direction, speed) or one init/shutdown frame and
// sends them one byte per cycle as the sink accepts. A frame of n data bytes
// is 8+n bytes long. A changed speed first runs the serial shift-add
// multiplier over the 16 scale bits. Input ready returns once the final byte
// of the last frame has entered the output register.
module vfd_command_frame_generator_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vfdcg_pkg::vfdcg_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vfdcg_pkg::vfdcg_out_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import vfdcg_pkg::*;

  vfdcg_top_state_e   state_q, state_d;
  logic [4:0]         slave_addr_q;
  logic [15:0]        cmd_scale_q;
  logic [15:0]        freq_limit_q;
  logic               prev_estop_q, prev_run_q, prev_fwd_q;
  logic [SPEED_W-1:0] prev_speed_q;
  logic               pend_f3_q, pend_fd_q, pend_fa_q, pend_ed_q;
  logic [7:0]         fa_char_q;
  logic [15:0]        ed_freq_q;

  logic               accept;
  logic [SPEED_W-1:0] spd, mag;
  logic               is_tick, estop_chg, estop_drop, rf_chg, spd_chg;
  logic               new_f3, new_fd, new_fa, new_ed;
  logic [7:0]         new_fa_char;
  logic [15:0]        scale_eff;
  logic               mul_done;
  logic [15:0]        mul_freq;
  logic               fr_start, fr_idle, fr_done;
  vfdcg_frame_t       fr_desc;
  logic               sel_f3, sel_fd, sel_fa, sel_ed;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // change detection on the incoming beat
  assign spd        = in_data_i.speed_command;
  assign mag        = spd[SPEED_W-1] ? (~spd + {{(SPEED_W-1){1'b0}}, 1'b1}) : spd;
  assign is_tick    = (in_data_i.cmd == CMD_TICK);
  assign estop_chg  = is_tick && (in_data_i.estop_ok != prev_estop_q);
  assign estop_drop = estop_chg && !in_data_i.estop_ok;
  assign rf_chg     = is_tick && !estop_drop && ((in_data_i.run_request != prev_run_q)
                      || (in_data_i.forward_dir != prev_fwd_q));
  assign spd_chg    = is_tick && !estop_drop && (spd != prev_speed_q);
  assign new_f3     = (in_data_i.cmd == CMD_INIT);
  assign new_fd     = estop_chg && in_data_i.estop_ok;
  assign new_fa     = (in_data_i.cmd == CMD_SHUTDOWN) || estop_drop || rf_chg;
  assign new_ed     = spd_chg;
  assign new_fa_char = (!rf_chg || !in_data_i.run_request) ? CH_0 :
                       (in_data_i.forward_dir ? CH_2 : CH_4);
  assign scale_eff  = (cmd_scale_q == 16'd0) ? SCALE_UNITY : cmd_scale_q;

  vfdcg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && new_ed),
    .mag_i   (mag),
    .scale_i (scale_eff),
    .limit_i (freq_limit_q),
    .done_o  (mul_done),
    .freq_o  (mul_freq)
  );

  // frame choice in send order
  assign sel_f3 = pend_f3_q;
  assign sel_fd = !sel_f3 && pend_fd_q;
  assign sel_fa = !sel_f3 && !sel_fd && pend_fa_q;
  assign sel_ed = !sel_f3 && !sel_fd && !sel_fa && pend_ed_q;

  always_comb begin
    fr_desc      = '0;
    fr_desc.last = ({pend_f3_q, pend_fd_q, pend_fa_q, pend_ed_q} &
                    ~{sel_f3, sel_fd, sel_fa, sel_ed}) == 4'd0;
    if (sel_f3) begin
      fr_desc.c0      = CH_F;
      fr_desc.c1      = CH_3;
      fr_desc.data[0] = CH_0;
      fr_desc.data[1] = CH_E;
      fr_desc.dlen    = DLEN_TWO;
    end else if (sel_fd) begin
      fr_desc.c0   = CH_F;
      fr_desc.c1   = CH_D;
      fr_desc.dlen = DLEN_NONE;
    end else if (sel_fa) begin
      fr_desc.c0      = CH_F;
      fr_desc.c1      = CH_A;
      fr_desc.data[0] = CH_0;
      fr_desc.data[1] = fa_char_q;
      fr_desc.dlen    = DLEN_TWO;
    end else begin
      fr_desc.c0      = CH_E;
      fr_desc.c1      = CH_D;
      fr_desc.data[0] = hex_char(ed_freq_q[15:12]);
      fr_desc.data[1] = hex_char(ed_freq_q[11:8]);
      fr_desc.data[2] = hex_char(ed_freq_q[7:4]);
      fr_desc.data[3] = hex_char(ed_freq_q[3:0]);
      fr_desc.dlen    = DLEN_FOUR;
    end
  end

  vfdcg_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (fr_start),
    .frame_i     (fr_desc),
    .station_i   (slave_addr_q),
    .idle_o      (fr_idle),
    .done_o      (fr_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: begin
        if (accept && new_ed) state_d = TOP_CALC;
        else if (accept && (new_f3 || new_fd || new_fa)) state_d = TOP_EMIT;
      end
      TOP_CALC: if (mul_done) state_d = TOP_EMIT;
      TOP_EMIT: if (fr_idle) state_d = TOP_WAIT;
      TOP_WAIT: begin
        if (fr_done) state_d = (pend_f3_q || pend_fd_q || pend_fa_q || pend_ed_q) ?
                               TOP_EMIT : TOP_IDLE;
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    fr_start   = 1'b0;
    case (state_q)
      TOP_IDLE: in_ready_o = 1'b1;
      TOP_EMIT: fr_start   = fr_idle;
      default: ;
    endcase
  end

  // control state, pending frames and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TOP_IDLE;
      slave_addr_q <= 5'd0;
      cmd_scale_q  <= SCALE_RESET;
      freq_limit_q <= LIMIT_RESET;
      prev_estop_q <= 1'b0;
      prev_run_q   <= 1'b0;
      prev_fwd_q   <= 1'b0;
      prev_speed_q <= '0;
      pend_f3_q    <= 1'b0;
      pend_fd_q    <= 1'b0;
      pend_fa_q    <= 1'b0;
      pend_ed_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[4:0];
          CFG_CMD_SCALE:  cmd_scale_q  <= cfg_data_i;
          CFG_FREQ_LIMIT: freq_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        pend_f3_q <= new_f3;
        pend_fd_q <= new_fd;
        pend_fa_q <= new_fa;
        pend_ed_q <= new_ed;
        if (estop_chg) prev_estop_q <= in_data_i.estop_ok;
        if (is_tick && !estop_drop) begin
          prev_run_q   <= in_data_i.run_request;
          prev_fwd_q   <= in_data_i.forward_dir;
          prev_speed_q <= spd;
        end
      end else if (fr_start) begin
        if (sel_f3) pend_f3_q <= 1'b0;
        if (sel_fd) pend_fd_q <= 1'b0;
        if (sel_fa) pend_fa_q <= 1'b0;
        if (sel_ed) pend_ed_q <= 1'b0;
      end
    end
  end

  // frame payload holding registers
  always_ff @(posedge clk_i) begin
    if (accept) fa_char_q <= new_fa_char;
    if (mul_done) ed_freq_q <= mul_freq;
  end

`ifndef SYNTHESIS
  // the item's final beat always closes a frame
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.last || out_data_o.frame_end))
    else $error("last beat without frame end");

  // the multiplier finishes only while a speed result is awaited
  a_mul_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == TOP_CALC))
    else $error("multiplier done outside calc");

  // a frame completes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_done |-> (state_q == TOP_WAIT))
    else $error("frame done outside wait");

  // a frame start always leaves the sequencer waiting on the frame unit
  a_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_start |=> (state_q == TOP_WAIT && !fr_idle))
    else $error("frame start not followed by send");
`endif

endmodule

[sv/vfdcg_mul.sv]
// ----------------------------------------------------------------------------
// vfdcg_mul
// Serial shift-add unit: freq = (mag * 100 * scale) >> 16, then saturated.
// ----------------------------------------------------------------------------
module vfdcg_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vfdcg_pkg::SPEED_W-1:0] mag_i,
  input  logic [15:0]                   scale_i,
  input  logic [15:0]                   limit_i,
  output logic                          done_o,
  output logic [15:0]                   freq_o
);
  import vfdcg_pkg::*;

  vfdcg_mul_state_e  state_q, state_d;
  logic [M100_W-1:0] m100_q;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [15:0]       scale_q;
  logic [3:0]        cnt_q;
  logic [M100_W-1:0] prod_hi;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MUL_IDLE: if (start_i) state_d = MUL_RUN;
      MUL_RUN:  if (cnt_q == 4'd0) state_d = MUL_SAT;
      MUL_SAT:  state_d = MUL_IDLE;
      default:  state_d = MUL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = 1'b0;
    case (state_q)
      MUL_SAT: done_o = 1'b1;
      default: done_o = 1'b0;
    endcase
  end

  // one scale bit per cycle, msb first
  assign acc_d = {acc_q[PROD_W-2:0], 1'b0}
               + (scale_q[cnt_q] ? {16'd0, m100_q} : {PROD_W{1'b0}});

  // saturation against the limit
  assign prod_hi = acc_q[PROD_W-1:16];
  assign freq_o  = (prod_hi > {{(M100_W-16){1'b0}}, limit_i}) ? limit_i : prod_hi[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
      cnt_q   <= 4'd15;
    end else begin
      state_q <= state_d;
      if (state_q == MUL_IDLE) cnt_q <= 4'd15;
      else if (state_q == MUL_RUN) cnt_q <= cnt_q - 4'd1;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (state_q == MUL_IDLE && start_i) begin
      m100_q  <= M100_W'({7'd0, mag_i} * M100_W'(100));
      scale_q <= scale_i;
      acc_q   <= '0;
    end else if (state_q == MUL_RUN) begin
      acc_q <= acc_d;
    end
  end

endmodule

[sv/vfdcg_frame.sv]
// ----------------------------------------------------------------------------
// vfdcg_frame
// Byte sequencer for one frame with running checksum and output register.
// ----------------------------------------------------------------------------
module vfdcg_frame (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  vfdcg_pkg::vfdcg_frame_t frame_i,
  input  logic [4:0]              station_i,
  output logic                    idle_o,
  output logic                    done_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output vfdcg_pkg::vfdcg_out_t   out_data_o
);
  import vfdcg_pkg::*;

  vfdcg_fr_state_e state_q, state_d;
  vfdcg_frame_t    frm_q;
  logic [3:0]      idx_q;
  logic [7:0]      sum_q;
  logic            ovalid_q;
  vfdcg_out_t      odata_q;
  logic            load;
  logic [3:0]      hi_idx;
  logic [3:0]      doff;
  logic            is_body;
  logic            is_end;
  logic [7:0]      cur_byte;

  assign hi_idx  = 4'd6 + {1'b0, frm_q.dlen};
  assign doff    = idx_q - 4'd6;
  assign is_body = (idx_q != 4'd0) && (idx_q < hi_idx);
  assign is_end  = (idx_q == hi_idx + 4'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (start_i) state_d = FR_SEND;
      FR_SEND: if (load && is_end) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_o = 1'b0;
    load   = 1'b0;
    case (state_q)
      FR_IDLE: idle_o = 1'b1;
      FR_SEND: load   = !ovalid_q || out_ready_i;
      default: idle_o = 1'b1;
    endcase
  end
  assign done_o = load && is_end;

  // byte at the current position
  always_comb begin
    if (idx_q == 4'd0) begin
      cur_byte = CH_ENQ;
    end else if (idx_q < 4'd6) begin
      case (idx_q)
        4'd1:    cur_byte = CH_0 + {6'd0, st_tens(station_i)};
        4'd2:    cur_byte = CH_0 + {4'd0, st_ones(station_i)};
        4'd3:    cur_byte = frm_q.c0;
        4'd4:    cur_byte = frm_q.c1;
        default: cur_byte = CH_1;
      endcase
    end else if (idx_q < hi_idx) begin
      cur_byte = frm_q.data[doff[1:0]];
    end else if (idx_q == hi_idx) begin
      cur_byte = hex_char(sum_q[7:4]);
    end else begin
      cur_byte = hex_char(sum_q[3:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // position, checksum and output beat
  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && start_i) begin
      frm_q <= frame_i;
      idx_q <= 4'd0;
      sum_q <= 8'd0;
    end else if (load) begin
      idx_q <= idx_q + 4'd1;
      if (is_body) sum_q <= sum_q + cur_byte;
    end
    if (load) begin
      odata_q.tx_byte   <= cur_byte;
      odata_q.frame_end <= is_end;
      odata_q.last      <= is_end && frm_q.last;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

[tb/sv/tb_vfd_command_frame_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_vfd_command_frame_generator_top
// Self-checking bench for the drive command frame generator. Input beats are
// mirrored into a behavioral frame builder that keeps its own copy of the
// estop, run, direction and speed history and of the three registers; every
// output beat is checked byte by byte against the frames it predicts.
// ----------------------------------------------------------------------------
module tb_vfd_command_frame_generator_top;
  import vfdcg_pkg::*;

  localparam int          STALL_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          PHASE_ITEMS  = 100;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam string       HEX_DIGITS   = "0123456789ABCDEF";

  // clock, reset and block ports
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  vfdcg_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  vfdcg_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = 2'd0;
  logic [15:0] cfg_data_i = 16'd0;

  // shadow registers and change-detection history
  logic [4:0]         cfg_station = 5'd0;
  logic [15:0]        cfg_scale   = SCALE_RESET;
  logic [15:0]        cfg_limit   = LIMIT_RESET;
  logic               seen_estop   = 1'b0;
  logic               seen_run     = 1'b0;
  logic               seen_forward = 1'b0;
  logic [SPEED_W-1:0] seen_speed   = '0;

  vfdcg_out_t expected_bytes[$];
  int         err_count      = 0;
  int         stall_cycles   = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  vfd_command_frame_generator_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sink back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // frame builder
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b, input logic frame_end);
    vfdcg_out_t beat;
    beat.tx_byte   = b;
    beat.frame_end = frame_end;
    beat.last      = 1'b0;
    expected_bytes.push_back(beat);
  endfunction

  // data bytes go out from the top of the word down
  function automatic void push_frame(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [31:0] data, input int dlen);
    logic [7:0] body [0:8];
    logic [7:0] sum;
    int         n;
    body[0] = CH_0 + 8'(cfg_station / 5'd10);
    body[1] = CH_0 + 8'(cfg_station % 5'd10);
    body[2] = c0;
    body[3] = c1;
    body[4] = CH_1;
    n = 5;
    for (int i = 0; i < dlen; i++) begin
      body[n] = data[31 - 8*i -: 8];
      n++;
    end
    push_byte(CH_ENQ, 1'b0);
    sum = 8'd0;
    for (int i = 0; i < n; i++) begin
      sum += body[i];
      push_byte(body[i], 1'b0);
    end
    push_byte(8'(HEX_DIGITS[sum[7:4]]), 1'b0);
    push_byte(8'(HEX_DIGITS[sum[3:0]]), 1'b1);
  endfunction

  // frequency word: |speed| * 100 * scale in Q8 x Q8, saturated at the limit
  function automatic logic [15:0] freq_word(input logic [SPEED_W-1:0] spd);
    logic [63:0] mag;
    logic [63:0] scl;
    logic [63:0] f;
    mag = spd[SPEED_W-1] ? 64'((~{1'b0, spd}) + 1'b1) & ((64'd1 << SPEED_W) - 1) : 64'(spd);
    if (spd[SPEED_W-1] && mag == 0) mag = 64'd1 << (SPEED_W - 1);
    scl = (cfg_scale == 16'd0) ? 64'(SCALE_UNITY) : 64'(cfg_scale);
    f   = (mag * 64'd100 * scl) >> 16;
    if (f > 64'(cfg_limit)) f = 64'(cfg_limit);
    return f[15:0];
  endfunction

  // expected frames of one input beat; returns the byte count
  function automatic int predict_frames(input vfdcg_in_t it);
    int          start;
    logic [15:0] f;
    logic [31:0] digits;
    vfdcg_out_t  tail;
    start = expected_bytes.size();
    case (it.cmd)
      CMD_INIT:     push_frame(CH_F, CH_3, {CH_0, CH_E, 16'd0}, 2);
      CMD_SHUTDOWN: push_frame(CH_F, CH_A, {CH_0, CH_0, 16'd0}, 2);
      CMD_TICK: begin
        if (it.estop_ok != seen_estop) begin
          seen_estop = it.estop_ok;
          if (it.estop_ok) push_frame(CH_F, CH_D, 32'd0, 0);
          else             push_frame(CH_F, CH_A, {CH_0, CH_0, 16'd0}, 2);
        end
        // an estop drop suppresses everything else on that tick
        if (!(it.estop_ok == 1'b0 && expected_bytes.size() != start)) begin
          if (it.run_request != seen_run || it.forward_dir != seen_forward) begin
            if (!it.run_request)     digits = {CH_0, CH_0, 16'd0};
            else if (it.forward_dir) digits = {CH_0, CH_2, 16'd0};
            else                     digits = {CH_0, CH_4, 16'd0};
            push_frame(CH_F, CH_A, digits, 2);
            seen_run     = it.run_request;
            seen_forward = it.forward_dir;
          end
          if (it.speed_command != seen_speed) begin
            f = freq_word(it.speed_command);
            digits = {8'(HEX_DIGITS[f[15:12]]), 8'(HEX_DIGITS[f[11:8]]),
                      8'(HEX_DIGITS[f[7:4]]), 8'(HEX_DIGITS[f[3:0]])};
            push_frame(CH_E, CH_D, digits, 4);
            seen_speed = it.speed_command;
          end
        end
      end
      default: ;
    endcase
    if (expected_bytes.size() != start) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
    return expected_bytes.size() - start;
  endfunction

  // ---------------------------------------------------------------------------
  // output check and watchdog
  // ---------------------------------------------------------------------------

  // compare each accepted output beat with the oldest expected byte
  always @(posedge clk_i) begin
    vfdcg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected beat tx_byte", out_data_o.tx_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data_o.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", out_data_o.tx_byte, want.tx_byte);
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", out_data_o.frame_end, want.frame_end);
        if (out_data_o.last !== want.last)
          report_mismatch("last", out_data_o.last, want.last);
      end
    end
  end

  // end the run when no channel has moved a beat for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input beat; valid stays high into the next call when no gap is drawn
  task automatic send_item(input vfdcg_in_t it, output int produced);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    produced = predict_frames(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SLAVE_ADDR: cfg_station = value[4:0];
      CFG_CMD_SCALE:  cfg_scale   = value;
      CFG_FREQ_LIMIT: cfg_limit   = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, let every expected byte drain, then give the block time to settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic vfdcg_in_t tick_item(input logic run, input logic fwd,
                                          input logic estop, input logic [SPEED_W-1:0] spd);
    vfdcg_in_t it;
    it.cmd           = CMD_TICK;
    it.run_request   = run;
    it.forward_dir   = fwd;
    it.estop_ok      = estop;
    it.speed_command = spd;
    return it;
  endfunction

  function automatic vfdcg_in_t cmd_item(input logic [1:0] code);
    vfdcg_in_t it;
    it = vfdcg_in_t'({$urandom, $urandom});
    it.cmd = code;
    return it;
  endfunction

  // mostly live ticks with estop closed; speed held, small, or any bit pattern
  function automatic vfdcg_in_t random_item();
    vfdcg_in_t          it;
    int                 r;
    logic [SPEED_W-1:0] spd;
    r = $urandom_range(99);
    if (r >= 84) begin
      if (r < 92)      it = cmd_item(CMD_INIT);
      else if (r < 97) it = cmd_item(CMD_SHUTDOWN);
      else             it = cmd_item(CMD_UNUSED);
    end else begin
      r = $urandom_range(99);
      if (r < 35) begin
        spd = seen_speed;
      end else if (r < 70) begin
        spd = SPEED_W'($urandom_range(0, 60000));
        if ($urandom_range(1)) spd = -spd;
      end else begin
        spd = SPEED_W'($urandom);
      end
      it = tick_item(seen_run ^ ($urandom_range(99) < 20),
                     seen_forward ^ ($urandom_range(99) < 15),
                     $urandom_range(99) < 94, spd);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // estop return and drop, pending changes held over a drop, run/direction codes
  task automatic test_estop_and_run();
    int n;
    send_item(tick_item(1'b0, 1'b0, 1'b1, 24'd0), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'd0), n);
    send_item(tick_item(1'b1, 1'b0, 1'b1, 24'd0), n);
    send_item(tick_item(1'b0, 1'b0, 1'b1, 24'd0), n);
    send_item(tick_item(1'b1, 1'b1, 1'b0, 24'h006400), n);
    send_item(tick_item(1'b1, 1'b1, 1'b0, 24'h006400), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h006400), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h006400), n);
    wait_idle();
  endtask

  // full-scale, most negative, minus one, one hertz and zero speed
  task automatic test_speed_extremes();
    int n;
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h7FFFFF), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h800000), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'hFFFFFF), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h000100), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h000000), n);
    wait_idle();
  endtask

  // init and shutdown frames, unused code yields nothing
  task automatic test_init_shutdown();
    int n;
    send_item(cmd_item(CMD_INIT), n);
    send_item(cmd_item(CMD_SHUTDOWN), n);
    send_item(cmd_item(CMD_UNUSED), n);
    wait_idle();
  endtask

  // station digits, scale extremes with zero as unity, zero and full limit
  task automatic test_config_extremes();
    int n;
    write_reg(CFG_SLAVE_ADDR, 16'd31);
    write_reg(CFG_CMD_SCALE, 16'hFFFF);
    write_reg(CFG_FREQ_LIMIT, 16'hFFFF);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h7FFFFF), n);
    send_item(tick_item(1'b1, 1'b1, 1'b1, 24'h000101), n);
    wait_idle();
    write_reg(CFG_SLAVE_ADDR, 16'd10);
    write_reg(CFG_CMD_SCALE, 16'd0);
    write_reg(CFG_FREQ_LIMIT, 16'd0);
    send_item(tick_item(1'b0, 1'b1, 1'b1, 24'd12345), n);
    send_item(cmd_item(CMD_INIT), n);
    wait_idle();
    write_reg(CFG_SLAVE_ADDR, 16'd9);
    write_reg(CFG_CMD_SCALE, 16'd1);
    write_reg(CFG_FREQ_LIMIT, 16'hFFFF);
    send_item(tick_item(1'b0, 1'b0, 1'b1, 24'h7FFFFF), n);
    send_item(cmd_item(CMD_SHUTDOWN), n);
    wait_idle();
  endtask

  // random registers, then a fixed number of random beats
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(31)));
    write_reg(CFG_CMD_SCALE, ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(65535)));
    write_reg(CFG_FREQ_LIMIT, 16'($urandom_range(65535)));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_item(random_item(), n);
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_estop_and_run();
    test_speed_extremes();
    test_init_shutdown();
    test_config_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(80, 0);
    test_random_traffic(0, 80);
    test_random_traffic(17, 17);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
